### rtl/fdd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the FM discriminator unit.
package fdd_pkg;

	// Field and state widths
	localparam int SAMPLE_W    = 8;
	localparam int CENTER_W    = 9;
	localparam int PROD_W      = 18;
	localparam int AUDIO_W     = 16;
	localparam int RATE_W      = 7;
	localparam int SCALE_W     = 17;
	localparam int ALPHA_W     = 16;
	localparam int GAIN_W      = 20;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;
	localparam int SUM_W       = 23;
	localparam int LEVEL_W     = 24;
	localparam int PHASE_W     = 17;
	localparam int ATAN_W      = 14;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_DECIMATION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA      = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN       = 2'd3;

	// Register reset values
	localparam logic [RATE_W-1:0]  RST_DECIMATION = 7'd40;
	localparam logic [SCALE_W-1:0] RST_SCALE      = 17'd1638;
	localparam logic [ALPHA_W-1:0] RST_ALPHA      = 16'd22328;
	localparam logic [GAIN_W-1:0]  RST_GAIN       = 20'd100531;

	// Previous sample after reset represents 1.0 + 0j
	localparam logic signed [CENTER_W-1:0] RST_PREV_I = 9'sd255;
	localparam logic signed [CENTER_W-1:0] RST_PREV_Q = 9'sd0;

	// Conjugate product of one pair, zero flags the degenerate vector
	typedef struct packed {
		logic                     zero;
		logic signed [PROD_W-1:0] re;
		logic signed [PROD_W-1:0] im;
	} prod_t;

	// Configuration registers as seen by the back end
	typedef struct packed {
		logic [RATE_W-1:0]  pair_rate;
		logic [SCALE_W-1:0] average_scale;
		logic [ALPHA_W-1:0] deemphasis_alpha;
		logic [GAIN_W-1:0]  output_gain;
	} cfg_t;

	// Rounded atan(2^-k) with 32768 = pi
	function automatic logic [ATAN_W-1:0] atan_step(input logic [4:0] k);
		logic [ATAN_W-1:0] a;
		unique case (k)
			5'd0:    a = 14'd8192;
			5'd1:    a = 14'd4836;
			5'd2:    a = 14'd2555;
			5'd3:    a = 14'd1297;
			5'd4:    a = 14'd651;
			5'd5:    a = 14'd326;
			5'd6:    a = 14'd163;
			5'd7:    a = 14'd81;
			5'd8:    a = 14'd41;
			5'd9:    a = 14'd20;
			5'd10:   a = 14'd10;
			5'd11:   a = 14'd5;
			5'd12:   a = 14'd3;
			5'd13:   a = 14'd1;
			5'd14:   a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

endpackage

### rtl/fdd_front.sv
`timescale 1ns / 1ps
// Front end: accepts I/Q pairs, centers them and forms the conjugate product.
module fdd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           iq_valid,
	output logic                           iq_stall,
	input  logic [fdd_pkg::SAMPLE_W-1:0]   i_sample,
	input  logic [fdd_pkg::SAMPLE_W-1:0]   q_sample,
	input  logic                           q_full,
	output logic                           push,
	output fdd_pkg::prod_t                 entry
);

	logic signed [fdd_pkg::CENTER_W-1:0] prev_i_q, prev_q_q;
	logic signed [fdd_pkg::CENTER_W-1:0] ci, cq;
	logic signed [fdd_pkg::PROD_W-1:0]   p_ii, p_qq, p_qi, p_iq;

	// Center as 2*raw - 255: flip the top bit and append a one
	assign ci = $signed({~i_sample[fdd_pkg::SAMPLE_W-1], i_sample[fdd_pkg::SAMPLE_W-2:0], 1'b1});
	assign cq = $signed({~q_sample[fdd_pkg::SAMPLE_W-1], q_sample[fdd_pkg::SAMPLE_W-2:0], 1'b1});

	// Multiply by the conjugate of the previous pair
	always_comb begin
		p_ii = ci * prev_i_q;
		p_qq = cq * prev_q_q;
		p_qi = cq * prev_i_q;
		p_iq = ci * prev_q_q;
		entry.re   = p_ii + p_qq;
		entry.im   = p_qi - p_iq;
		entry.zero = (entry.re == '0) && (entry.im == '0);
	end

	// Accept while the queue has room
	assign iq_stall = q_full;
	assign push     = iq_valid && !q_full;

	// Hold the last centered pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q <= fdd_pkg::RST_PREV_I;
			prev_q_q <= fdd_pkg::RST_PREV_Q;
		end else if (push) begin
			prev_i_q <= ci;
			prev_q_q <= cq;
		end
	end

endmodule

### rtl/fdd_queue.sv
`timescale 1ns / 1ps
// Short queue of conjugate products between front and back end.
module fdd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fdd_pkg::prod_t  wr_entry,
	input  logic            pop,
	output fdd_pkg::prod_t  rd_entry,
	output logic            full,
	output logic            empty
);

	localparam int PW = $clog2(fdd_pkg::QUEUE_DEPTH);
	localparam int CNTW = $clog2(fdd_pkg::QUEUE_DEPTH + 1);

	fdd_pkg::prod_t     mem_q [fdd_pkg::QUEUE_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]    count_q;

	assign full     = (count_q == CNTW'(fdd_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(fdd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(fdd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/fdd_back.sv
`timescale 1ns / 1ps
// Back end: serial CORDIC phase, decimation sum, de-emphasis, gain and output register.
module fdd_back #(
	parameter int CORDIC_STEPS   = 16,
	parameter int MAX_DECIMATION = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fdd_pkg::cfg_t                       cfg,
	input  fdd_pkg::prod_t                      entry,
	input  logic                                q_empty,
	output logic                                pop,
	output logic                                audio_valid,
	input  logic                                audio_stall,
	output logic signed [fdd_pkg::AUDIO_W-1:0]  pcm_sample
);

	localparam int KW   = $clog2(CORDIC_STEPS);
	localparam int CW   = $clog2(MAX_DECIMATION + 1);
	localparam int RW   = (CW > fdd_pkg::RATE_W) ? CW : fdd_pkg::RATE_W;
	localparam int XW   = 29;
	localparam int ZW   = 18;
	localparam int AVW  = fdd_pkg::SUM_W + fdd_pkg::SCALE_W + 1;
	localparam int DW   = fdd_pkg::LEVEL_W + 1;
	localparam int FW   = DW + fdd_pkg::ALPHA_W + 1;
	localparam int GW   = fdd_pkg::LEVEL_W + fdd_pkg::GAIN_W + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ROT  = 9'b000000010,
		ST_ACC  = 9'b000000100,
		ST_AVG  = 9'b000001000,
		ST_DIFF = 9'b000010000,
		ST_FILT = 9'b000100000,
		ST_UPD  = 9'b001000000,
		ST_GAIN = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t                                state_q;
	logic [KW-1:0]                         k_q;
	logic signed [XW-1:0]                  x_q, y_q;
	logic signed [ZW-1:0]                  z_q;
	logic                                  zero_q;
	logic [CW-1:0]                         cnt_q;
	logic signed [fdd_pkg::SUM_W-1:0]      sum_q;
	logic signed [fdd_pkg::LEVEL_W-1:0]    level_q;
	logic signed [AVW-1:0]                 avg_prod_q;
	logic signed [DW-1:0]                  diff_q;
	logic signed [FW-1:0]                  filt_prod_q;
	logic signed [GW-1:0]                  gain_prod_q;
	logic                                  audio_valid_q;
	logic signed [fdd_pkg::AUDIO_W-1:0]    audio_q;

	logic signed [XW-1:0]                  x0, y0, x_init, y_init, dx, dy;
	logic signed [ZW-1:0]                  z_init, atan_ext;
	logic signed [fdd_pkg::PHASE_W-1:0]    phase;
	logic signed [fdd_pkg::SUM_W:0]        sum_w;
	logic signed [fdd_pkg::SUM_W-1:0]      sum_c;
	logic [RW-1:0]                         rate_ext, rate_eff;
	logic [CW-1:0]                         cnt_next;
	logic                                  emit;
	logic signed [AVW-1:0]                 avg_w;
	logic signed [fdd_pkg::LEVEL_W-1:0]    avg_c;
	logic signed [FW-1:0]                  step_w, upd_w;
	logic signed [fdd_pkg::LEVEL_W-1:0]    level_c;
	logic signed [GW:0]                    trunc_w;
	logic signed [GW:0]                    audio_w;
	logic signed [fdd_pkg::AUDIO_W-1:0]    audio_c;
	logic signed [fdd_pkg::SCALE_W:0]      scale_s;
	logic signed [fdd_pkg::ALPHA_W:0]      alpha_s;
	logic signed [fdd_pkg::GAIN_W:0]       gain_s;
	logic                                  out_free;

	assign scale_s = $signed({1'b0, cfg.average_scale});
	assign alpha_s = $signed({1'b0, cfg.deemphasis_alpha});
	assign gain_s  = $signed({1'b0, cfg.output_gain});

	assign pop          = (state_q == ST_IDLE) && !q_empty;
	assign out_free     = !audio_valid_q || !audio_stall;
	assign audio_valid  = audio_valid_q;
	assign pcm_sample   = audio_q;

	// Scale by 256 and turn a left-half vector by 90 degrees
	always_comb begin
		x0 = {{(XW - fdd_pkg::PROD_W - 8){entry.re[fdd_pkg::PROD_W-1]}}, entry.re, 8'd0};
		y0 = {{(XW - fdd_pkg::PROD_W - 8){entry.im[fdd_pkg::PROD_W-1]}}, entry.im, 8'd0};
		x_init = x0;
		y_init = y0;
		z_init = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				x_init = y0;
				y_init = -x0;
				z_init = 18'sd16384;
			end else begin
				x_init = -y0;
				y_init = x0;
				z_init = -18'sd16384;
			end
		end
	end

	// One micro-rotation per cycle
	assign dx       = y_q >>> k_q;
	assign dy       = x_q >>> k_q;
	assign atan_ext = $signed({{(ZW - fdd_pkg::ATAN_W){1'b0}},
		fdd_pkg::atan_step(5'(k_q))});

	// Clamp the phase step, saturate the sum, check the pair count
	always_comb begin
		if (zero_q) begin
			phase = '0;
		end else if (z_q > 18'sd32768) begin
			phase = 17'sh08000;
		end else if (z_q < -18'sd32768) begin
			phase = 17'sh18000;
		end else begin
			phase = z_q[fdd_pkg::PHASE_W-1:0];
		end
		sum_w = {sum_q[fdd_pkg::SUM_W-1], sum_q}
			+ {{(fdd_pkg::SUM_W + 1 - fdd_pkg::PHASE_W){phase[fdd_pkg::PHASE_W-1]}}, phase};
		if (sum_w > 24'sd4194303) begin
			sum_c = 23'sh3FFFFF;
		end else if (sum_w < -24'sd4194304) begin
			sum_c = 23'sh400000;
		end else begin
			sum_c = sum_w[fdd_pkg::SUM_W-1:0];
		end
		rate_ext = RW'(cfg.pair_rate);
		if (rate_ext == '0) begin
			rate_eff = RW'(1);
		end else if (rate_ext > RW'(MAX_DECIMATION)) begin
			rate_eff = RW'(MAX_DECIMATION);
		end else begin
			rate_eff = rate_ext;
		end
		cnt_next = cnt_q + 1'b1;
		emit     = (RW'(cnt_next) >= rate_eff);
	end

	// Round the average and saturate it to the level width
	always_comb begin
		avg_w = (avg_prod_q + AVW'(128)) >>> 8;
		if (avg_w > AVW'(8388607)) begin
			avg_c = 24'sh7FFFFF;
		end else if (avg_w < -AVW'(8388608)) begin
			avg_c = 24'sh800000;
		end else begin
			avg_c = avg_w[fdd_pkg::LEVEL_W-1:0];
		end
	end

	// Round the filter step and update the level
	always_comb begin
		step_w = (filt_prod_q + FW'(32768)) >>> 16;
		upd_w  = FW'(level_q) + step_w;
		if (upd_w > FW'(8388607)) begin
			level_c = 24'sh7FFFFF;
		end else if (upd_w < -FW'(8388608)) begin
			level_c = 24'sh800000;
		end else begin
			level_c = upd_w[fdd_pkg::LEVEL_W-1:0];
		end
	end

	// Truncate the gained level toward zero and saturate to 16 bits
	always_comb begin
		trunc_w = (GW + 1)'(gain_prod_q);
		if (gain_prod_q < 0) begin
			trunc_w = trunc_w + (GW + 1)'(24'hFFFFFF);
		end
		audio_w = trunc_w >>> 24;
		if (audio_w > (GW + 1)'(32767)) begin
			audio_c = 16'sh7FFF;
		end else if (audio_w < -(GW + 1)'(32768)) begin
			audio_c = 16'sh8000;
		end else begin
			audio_c = audio_w[fdd_pkg::AUDIO_W-1:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q    <= x_init;
				y_q    <= y_init;
				z_q    <= z_init;
				zero_q <= entry.zero;
			end
			ST_ROT: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_ext;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_ext;
				end
			end
			ST_AVG:  avg_prod_q  <= sum_q * scale_s;
			ST_DIFF: diff_q      <= DW'(avg_c) - DW'(level_q);
			ST_FILT: filt_prod_q <= diff_q * alpha_s;
			ST_GAIN: gain_prod_q <= level_q * gain_s;
			ST_OUT: begin
				if (out_free) begin
					audio_q <= audio_c;
				end
			end
			default: begin
			end
		endcase
	end

	// Raise the output valid on a finished sample, drop it after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			audio_valid_q <= 1'b1;
		end else if (audio_valid_q && !audio_stall) begin
			audio_valid_q <= 1'b0;
		end
	end

	// Sequencer, decimation state and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= '0;
			cnt_q         <= '0;
			sum_q         <= '0;
			level_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (!q_empty) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					k_q <= k_q + 1'b1;
					if (k_q == KW'(CORDIC_STEPS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q <= sum_c;
					if (emit) begin
						cnt_q   <= '0;
						state_q <= ST_AVG;
					end else begin
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				ST_AVG: begin
					sum_q   <= '0;
					state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_FILT;
				ST_FILT: state_q <= ST_UPD;
				ST_UPD: begin
					level_q <= level_c;
					state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/fm_discriminator_decimate_deemph_unit.sv
`timescale 1ns / 1ps
// Top level: FM polar discriminator with decimation, de-emphasis and gain.
// Sequence: with the back end idle a pair is loaded, rotated in CORDIC_STEPS steps and
//   accumulated; an emitting pair then passes the average, difference, filter, update,
//   gain and output states. The back end takes a new pair only once it is idle again;
//   the 4-entry queue takes pairs ahead and an output stall holds the back end.
// Reset: asynchronous; registers return to their defaults, previous pair to 1.0, sums clear.
module fm_discriminator_decimate_deemph_unit #(
	parameter int CORDIC_STEPS   = 16,
	parameter int MAX_DECIMATION = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 iq_valid,
	output logic                                 iq_stall,
	input  logic [fdd_pkg::SAMPLE_W-1:0]         i_sample,
	input  logic [fdd_pkg::SAMPLE_W-1:0]         q_sample,
	output logic                                 audio_valid,
	input  logic                                 audio_stall,
	output logic signed [fdd_pkg::AUDIO_W-1:0]   pcm_sample,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fdd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fdd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	fdd_pkg::cfg_t   cfg_q;
	fdd_pkg::prod_t  wr_entry, rd_entry;
	logic            push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pair_rate        <= fdd_pkg::RST_DECIMATION;
			cfg_q.average_scale    <= fdd_pkg::RST_SCALE;
			cfg_q.deemphasis_alpha <= fdd_pkg::RST_ALPHA;
			cfg_q.output_gain      <= fdd_pkg::RST_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fdd_pkg::CFG_DECIMATION:
					cfg_q.pair_rate        <= cfg_data[fdd_pkg::RATE_W-1:0];
				fdd_pkg::CFG_SCALE:
					cfg_q.average_scale    <= cfg_data[fdd_pkg::SCALE_W-1:0];
				fdd_pkg::CFG_ALPHA:
					cfg_q.deemphasis_alpha <= cfg_data[fdd_pkg::ALPHA_W-1:0];
				fdd_pkg::CFG_GAIN:
					cfg_q.output_gain      <= cfg_data[fdd_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fdd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.iq_valid (iq_valid),
		.iq_stall (iq_stall),
		.i_sample (i_sample),
		.q_sample (q_sample),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	fdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	fdd_back #(
		.CORDIC_STEPS   (CORDIC_STEPS),
		.MAX_DECIMATION (MAX_DECIMATION)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.entry        (rd_entry),
		.q_empty      (q_empty),
		.pop          (pop),
		.audio_valid  (audio_valid),
		.audio_stall  (audio_stall),
		.pcm_sample   (pcm_sample)
	);

	// Back end never drains an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	// Queue cannot report full and empty together
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	// A transfer without a pop leaves the queue holding an entry
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(iq_valid && !iq_stall && !pop) |=> !q_empty)
		else $error("accepted pair lost from queue");

endmodule
